/* design/ehtu_pkg.sv */
// ----------------------------------------------------------------------------
// ehtu_pkg
// Shared types and codes of the extendible hash table unit.
// ----------------------------------------------------------------------------
package ehtu_pkg;

    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int ACT_W       = 2;
    localparam int ST_W        = 2;
    localparam int DEPTH_OUT_W = 3;
    localparam int COUNT_OUT_W = 7;
    localparam int CAP_W       = 4;

    localparam logic [CAP_W-1:0] CAP_RESET = 4'd4;

    // request actions
    localparam logic [ACT_W-1:0] ACT_FIND   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

    // response status codes
    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_MISS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } ehtu_req_t;

    typedef struct packed {
        logic [ST_W-1:0]        status;
        logic [VAL_W-1:0]       found_value;
        logic [DEPTH_OUT_W-1:0] depth_now;
        logic [COUNT_OUT_W-1:0] bucket_count;
        logic [DEPTH_OUT_W-1:0] key_local_depth;
    } ehtu_rsp_t;

endpackage

/* design/ehtu_ram.sv */
// ----------------------------------------------------------------------------
// ehtu_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ehtu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* design/extendible_hash_table_unit.sv */
// ----------------------------------------------------------------------------
// extendible_hash_table_unit
// Extendible hash table of key/value pairs with find, insert and remove.
// ----------------------------------------------------------------------------
// A request (action, key, value) is taken at a clock edge with start high and
// busy low. Exactly one response follows, shown on rsp for one cycle with done
// high; the receiver cannot hold it off, and a new request may be taken in
// the cycle the response is shown.
// The directory, the bucket depths and the bucket rows (valid bits, keys and
// values of all slots of one bucket) sit in three RAMs with registered reads.
// A request without a split runs a directory read, a row read, then the row
// is checked and written back in one step. Each split of a full bucket adds
// the new bucket's row write, a directory sweep over 2^(global depth) entries
// (2^(old depth) when the directory doubles, the upper half being written
// from the lower), a drain state and a relook state, and another directory
// and row read. After reset a clearing pass over the three RAMs steps
// through max(2^MAX_DEPTH, MAX_BUCKETS) addresses with busy high. The
// capacity register is written through cfg_wr_en/cfg_wr_data at any time,
// reset value 4.
// ----------------------------------------------------------------------------
module extendible_hash_table_unit
    import ehtu_pkg::*;
#(
    parameter int MAX_DEPTH        = 6,
    parameter int MAX_BUCKETS      = 64,
    parameter int SLOTS_PER_BUCKET = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  ehtu_req_t        req,
    output logic             done,
    output ehtu_rsp_t        rsp,
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data
);

    localparam int MD     = MAX_DEPTH;
    localparam int DIR_N  = 1 << MAX_DEPTH;
    localparam int SLOTS  = SLOTS_PER_BUCKET;
    localparam int BW     = $clog2(MAX_BUCKETS);
    localparam int DW     = $clog2(MAX_DEPTH + 1);
    localparam int UW     = $clog2(MAX_BUCKETS + 1);
    localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int OW     = $clog2(SLOTS + 1);
    localparam int CLR_N  = (DIR_N > MAX_BUCKETS) ? DIR_N : MAX_BUCKETS;
    localparam int CW     = $clog2(CLR_N);
    localparam int ROW_W  = SLOTS * (1 + KEY_W + VAL_W);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIR   = 3'd2;
    localparam logic [2:0] S_ROW   = 3'd3;
    localparam logic [2:0] S_SPLIT = 3'd4;
    localparam logic [2:0] S_SWEEP = 3'd5;
    localparam logic [2:0] S_DRAIN = 3'd6;
    localparam logic [2:0] S_LOOK  = 3'd7;

    // registers
    logic [2:0]       state_reg,     state_next;
    ehtu_req_t        req_reg,       req_next;
    logic [BW-1:0]    b_reg,         b_next;
    logic [BW-1:0]    nb_reg,        nb_next;
    logic [DW-1:0]    ld_reg,        ld_next;
    logic             dbl_reg,       dbl_next;
    logic [ROW_W-1:0] nb_row_reg,    nb_row_next;
    logic [DW-1:0]    gd_reg,        gd_next;
    logic [UW-1:0]    used_reg,      used_next;
    logic [CAP_W-1:0] cap_reg;
    logic [CW-1:0]    clr_cnt_reg,   clr_cnt_next;
    logic [MD-1:0]    sw_cnt_reg,    sw_cnt_next;
    logic [MD-1:0]    sw_last_reg,   sw_last_next;
    logic             pend_v_reg,    pend_v_next;
    logic [MD-1:0]    pend_addr_reg, pend_addr_next;
    logic             done_reg,      done_next;
    ehtu_rsp_t        rsp_reg,       rsp_next;

    // ram ports
    logic             dir_we;
    logic [MD-1:0]    dir_waddr, dir_raddr;
    logic [BW-1:0]    dir_wdata, dir_rd;
    logic             row_we;
    logic [BW-1:0]    row_waddr, row_raddr;
    logic [ROW_W-1:0] row_wdata, row_rd;
    logic             dep_we;
    logic [BW-1:0]    dep_waddr, dep_raddr;
    logic [DW-1:0]    dep_wdata, dep_rd;

    ehtu_ram #(.WIDTH(BW), .DEPTH(DIR_N)) u_dir (
        .clk   (clk),
        .we    (dir_we),
        .waddr (dir_waddr),
        .wdata (dir_wdata),
        .raddr (dir_raddr),
        .rdata (dir_rd)
    );

    ehtu_ram #(.WIDTH(ROW_W), .DEPTH(MAX_BUCKETS)) u_row (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .raddr (row_raddr),
        .rdata (row_rd)
    );

    ehtu_ram #(.WIDTH(DW), .DEPTH(MAX_BUCKETS)) u_dep (
        .clk   (clk),
        .we    (dep_we),
        .waddr (dep_waddr),
        .wdata (dep_wdata),
        .raddr (dep_raddr),
        .rdata (dep_rd)
    );

    // directory index masks
    logic [MD-1:0] gd_mask;
    logic [MD-1:0] ld_bit;
    logic [MD-1:0] pend_waddr;

    assign gd_mask    = ~({MD{1'b1}} << gd_reg);
    assign ld_bit     = MD'(1) << ld_reg;
    assign pend_waddr = pend_addr_reg | (dbl_reg ? ld_bit : '0);

    // bucket row fields
    logic [SLOTS-1:0]            row_valid;
    logic [SLOTS-1:0][KEY_W-1:0] row_keys;
    logic [SLOTS-1:0][VAL_W-1:0] row_vals;

    assign row_valid = row_rd[SLOTS-1:0];
    assign row_keys  = row_rd[SLOTS +: SLOTS*KEY_W];
    assign row_vals  = row_rd[SLOTS + SLOTS*KEY_W +: SLOTS*VAL_W];

    // row analysis: hit, free slot, occupancy, split halves
    logic [SLOTS-1:0]            hit_vec;
    logic                        hit;
    logic [SW-1:0]               hit_idx;
    logic [SW-1:0]               free_idx;
    logic [OW-1:0]               occ;
    logic [OW-1:0]               cap_eff;
    logic [SLOTS-1:0]            moved;
    logic [SLOTS-1:0]            nb_valid;
    logic [SLOTS-1:0][KEY_W-1:0] nb_keys;
    logic [SLOTS-1:0][VAL_W-1:0] nb_vals;
    logic [OW-1:0]               nb_cnt;
    logic [KEY_W-1:0]            shk;

    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        occ      = '0;
        nb_valid = '0;
        nb_keys  = '0;
        nb_vals  = '0;
        nb_cnt   = '0;
        shk      = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            hit_vec[s] = row_valid[s] && (row_keys[s] == req_reg.key);
            if (hit_vec[s])
            begin
                hit_idx = SW'(s);
            end
            if (!row_valid[s])
            begin
                free_idx = SW'(s);
            end
        end
        for (int s = 0; s < SLOTS; s++)
        begin
            occ = occ + OW'(row_valid[s]);
            shk = row_keys[s] >> dep_rd;
            moved[s] = row_valid[s] && shk[0];
            if (moved[s])
            begin
                nb_valid[nb_cnt[SW-1:0]] = 1'b1;
                nb_keys[nb_cnt[SW-1:0]]  = row_keys[s];
                nb_vals[nb_cnt[SW-1:0]]  = row_vals[s];
                nb_cnt = nb_cnt + OW'(1);
            end
        end
        hit = |hit_vec;
    end

    // effective capacity clamp
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = OW'(1);
        end
        else if (int'(cap_reg) > SLOTS)
        begin
            cap_eff = OW'(SLOTS);
        end
        else
        begin
            cap_eff = OW'(cap_reg);
        end
    end

    // control sequencer
    logic                        is_full;
    logic [SLOTS-1:0]            mod_valid;
    logic [SLOTS-1:0][KEY_W-1:0] mod_keys;
    logic [SLOTS-1:0][VAL_W-1:0] mod_vals;

    assign is_full = (int'(dep_rd) >= MAX_DEPTH) || (int'(used_reg) >= MAX_BUCKETS);

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        b_next         = b_reg;
        nb_next        = nb_reg;
        ld_next        = ld_reg;
        dbl_next       = dbl_reg;
        nb_row_next    = nb_row_reg;
        gd_next        = gd_reg;
        used_next      = used_reg;
        clr_cnt_next   = clr_cnt_reg;
        sw_cnt_next    = sw_cnt_reg;
        sw_last_next   = sw_last_reg;
        pend_v_next    = 1'b0;
        pend_addr_next = pend_addr_reg;
        done_next      = 1'b0;
        rsp_next       = rsp_reg;
        mod_valid      = row_valid;
        mod_keys       = row_keys;
        mod_vals       = row_vals;

        dir_raddr = '0;
        dir_we    = 1'b0;
        dir_waddr = '0;
        dir_wdata = '0;
        row_raddr = dir_rd;
        row_we    = 1'b0;
        row_waddr = '0;
        row_wdata = '0;
        dep_raddr = dir_rd;
        dep_we    = 1'b0;
        dep_waddr = '0;
        dep_wdata = '0;

        // pending directory sweep write
        if (pend_v_reg)
        begin
            dir_we    = 1'b1;
            dir_waddr = pend_waddr;
            dir_wdata = ((dir_rd == b_reg) && ((pend_waddr & ld_bit) != '0)) ? nb_reg : dir_rd;
        end

        case (state_reg)
            S_CLEAR:
            begin
                if (int'(clr_cnt_reg) < DIR_N)
                begin
                    dir_we    = 1'b1;
                    dir_waddr = clr_cnt_reg[MD-1:0];
                    dir_wdata = '0;
                end
                if (int'(clr_cnt_reg) < MAX_BUCKETS)
                begin
                    row_we    = 1'b1;
                    row_waddr = clr_cnt_reg[BW-1:0];
                    row_wdata = '0;
                    dep_we    = 1'b1;
                    dep_waddr = clr_cnt_reg[BW-1:0];
                    dep_wdata = '0;
                end
                if (clr_cnt_reg == CW'(CLR_N - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + CW'(1);
                end
            end
            S_IDLE:
            begin
                dir_raddr = req.key[MD-1:0] & gd_mask;
                if (start)
                begin
                    req_next   = req;
                    state_next = S_DIR;
                end
            end
            S_LOOK:
            begin
                dir_raddr  = req_reg.key[MD-1:0] & gd_mask;
                state_next = S_DIR;
            end
            S_DIR:
            begin
                b_next     = dir_rd;
                state_next = S_ROW;
            end
            S_ROW:
            begin
                rsp_next.status          = ST_MISS;
                rsp_next.found_value     = '0;
                rsp_next.depth_now       = DEPTH_OUT_W'(gd_reg);
                rsp_next.bucket_count    = COUNT_OUT_W'(used_reg);
                rsp_next.key_local_depth = DEPTH_OUT_W'(dep_rd);
                done_next                = 1'b1;
                state_next               = S_IDLE;
                row_waddr                = b_reg;
                case (req_reg.action)
                    ACT_FIND:
                    begin
                        if (hit)
                        begin
                            rsp_next.status      = ST_OK;
                            rsp_next.found_value = row_vals[hit_idx];
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (hit)
                        begin
                            rsp_next.status    = ST_OK;
                            mod_valid[hit_idx] = 1'b0;
                            row_we             = 1'b1;
                        end
                    end
                    ACT_INSERT:
                    begin
                        if (hit)
                        begin
                            rsp_next.status   = ST_OK;
                            mod_vals[hit_idx] = req_reg.value;
                            row_we            = 1'b1;
                        end
                        else if (occ < cap_eff)
                        begin
                            rsp_next.status     = ST_OK;
                            mod_valid[free_idx] = 1'b1;
                            mod_keys[free_idx]  = req_reg.key;
                            mod_vals[free_idx]  = req_reg.value;
                            row_we              = 1'b1;
                        end
                        else if (is_full)
                        begin
                            rsp_next.status = ST_FULL;
                        end
                        else
                        begin
                            // split: keep low half here, stage high half
                            done_next   = 1'b0;
                            state_next  = S_SPLIT;
                            mod_valid   = row_valid & ~moved;
                            row_we      = 1'b1;
                            dep_we      = 1'b1;
                            dep_waddr   = b_reg;
                            dep_wdata   = DW'(dep_rd + DW'(1));
                            ld_next     = dep_rd;
                            dbl_next    = (dep_rd == gd_reg);
                            nb_next     = used_reg[BW-1:0];
                            nb_row_next = {nb_vals, nb_keys, nb_valid};
                        end
                    end
                    default:
                    begin
                        rsp_next.status = ST_MISS;
                    end
                endcase
                row_wdata = {mod_vals, mod_keys, mod_valid};
            end
            S_SPLIT:
            begin
                row_we       = 1'b1;
                row_waddr    = nb_reg;
                row_wdata    = nb_row_reg;
                dep_we       = 1'b1;
                dep_waddr    = nb_reg;
                dep_wdata    = DW'(ld_reg + DW'(1));
                used_next    = used_reg + UW'(1);
                if (dbl_reg)
                begin
                    gd_next = gd_reg + DW'(1);
                end
                sw_last_next = MD'((MD'(1) << (dbl_reg ? ld_reg : gd_reg)) - MD'(1));
                sw_cnt_next  = '0;
                state_next   = S_SWEEP;
            end
            S_SWEEP:
            begin
                dir_raddr      = sw_cnt_reg;
                pend_v_next    = 1'b1;
                pend_addr_next = sw_cnt_reg;
                if (sw_cnt_reg == sw_last_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    sw_cnt_next = sw_cnt_reg + MD'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_LOOK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            gd_reg      <= '0;
            used_reg    <= UW'(1);
            cap_reg     <= CAP_RESET;
            clr_cnt_reg <= '0;
            pend_v_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            gd_reg      <= gd_next;
            used_reg    <= used_next;
            clr_cnt_reg <= clr_cnt_next;
            pend_v_reg  <= pend_v_next;
            done_reg    <= done_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        b_reg         <= b_next;
        nb_reg        <= nb_next;
        ld_reg        <= ld_next;
        dbl_reg       <= dbl_next;
        nb_row_reg    <= nb_row_next;
        sw_cnt_reg    <= sw_cnt_next;
        sw_last_reg   <= sw_last_next;
        pend_addr_reg <= pend_addr_next;
        rsp_reg       <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // checks
    a_done_after_row: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_ROW))
        else $error("response without row step");

    a_split_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SPLIT) |-> (int'(used_reg) < MAX_BUCKETS))
        else $error("split past bucket limit");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(gd_reg) <= MAX_DEPTH)
        else $error("global depth past limit");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but not busy");

endmodule

/* bench/tb_extendible_hash_table_unit.sv */
// ----------------------------------------------------------------------------
// tb_extendible_hash_table_unit
// Self-checking bench for the extendible hash table unit.
// ----------------------------------------------------------------------------
// Requests are fed through the start/busy handshake. A behavioral table in the
// scoreboard mirrors the directory, bucket depths and slots and predicts one
// response per request, and each done pulse is compared field by field.
// Phases walk the capacity register through its extremes and out-of-range
// codes, with sender gaps varied across the phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// behavioral mirror of the table plus the queue of predicted responses
class ehtu_scoreboard;
    localparam int DEPTH_MAX = 6;
    localparam int BKT_MAX   = 64;
    localparam int SLOTS     = 8;

    int unsigned dir_map [64];
    int unsigned bkt_depth [BKT_MAX];
    bit [31:0]   slot_key [BKT_MAX*SLOTS];
    bit [31:0]   slot_val [BKT_MAX*SLOTS];
    bit          slot_used [BKT_MAX*SLOTS];
    int unsigned gdepth;
    int unsigned nbuckets;
    bit [3:0]    capacity;
    ehtu_pkg::ehtu_rsp_t pending_rsp [$];
    int          mismatches;

    function new();
        foreach (dir_map[i]) dir_map[i] = 0;
        foreach (bkt_depth[i]) bkt_depth[i] = 0;
        foreach (slot_used[i]) slot_used[i] = 0;
        gdepth = 0;
        nbuckets = 1;
        capacity = ehtu_pkg::CAP_RESET;
        mismatches = 0;
    endfunction

    function int unsigned bucket_of(bit [31:0] k);
        return dir_map[k & ((32'd1 << gdepth) - 1)];
    endfunction

    function int find_slot(int unsigned b, bit [31:0] k);
        for (int s = 0; s < SLOTS; s++)
            if (slot_used[b*SLOTS+s] && slot_key[b*SLOTS+s] == k) return b*SLOTS + s;
        return -1;
    endfunction

    function void place(int unsigned b, bit [31:0] k, bit [31:0] v);
        for (int s = 0; s < SLOTS; s++)
            if (!slot_used[b*SLOTS+s])
            begin
                slot_used[b*SLOTS+s] = 1;
                slot_key[b*SLOTS+s] = k;
                slot_val[b*SLOTS+s] = v;
                return;
            end
    endfunction

    function void split_bucket(int unsigned b);
        int unsigned ld;
        int unsigned nb;
        ld = bkt_depth[b];
        nb = nbuckets;
        if (ld == gdepth)
        begin
            for (int i = 0; i < (1 << gdepth); i++) dir_map[i + (1 << gdepth)] = dir_map[i];
            gdepth++;
        end
        bkt_depth[b] = ld + 1;
        bkt_depth[nb] = ld + 1;
        nbuckets++;
        for (int i = 0; i < (1 << gdepth); i++)
            if (dir_map[i] == b && ((i >> ld) & 1)) dir_map[i] = nb;
        for (int s = 0; s < SLOTS; s++)
            if (slot_used[b*SLOTS+s] && slot_key[b*SLOTS+s][ld])
            begin
                place(nb, slot_key[b*SLOTS+s], slot_val[b*SLOTS+s]);
                slot_used[b*SLOTS+s] = 0;
            end
    endfunction

    function bit [1:0] insert_key(bit [31:0] k, bit [31:0] v);
        int unsigned b;
        int at;
        int unsigned occ;
        int unsigned cap;
        cap = (capacity < 1) ? 1 : (capacity > SLOTS) ? SLOTS : capacity;
        forever
        begin
            b = bucket_of(k);
            at = find_slot(b, k);
            if (at >= 0)
            begin
                slot_val[at] = v;
                return ehtu_pkg::ST_OK;
            end
            occ = 0;
            for (int s = 0; s < SLOTS; s++) occ += slot_used[b*SLOTS+s];
            if (occ < cap)
            begin
                place(b, k, v);
                return ehtu_pkg::ST_OK;
            end
            if (bkt_depth[b] >= DEPTH_MAX || nbuckets >= BKT_MAX) return ehtu_pkg::ST_FULL;
            split_bucket(b);
        end
    endfunction

    // note an accepted request and queue its predicted response
    function void note_request(ehtu_pkg::ehtu_req_t rq);
        ehtu_pkg::ehtu_rsp_t r;
        int at;
        r = '0;
        r.status = ehtu_pkg::ST_MISS;
        if (rq.action == ehtu_pkg::ACT_FIND)
        begin
            at = find_slot(bucket_of(rq.key), rq.key);
            if (at >= 0)
            begin
                r.status = ehtu_pkg::ST_OK;
                r.found_value = slot_val[at];
            end
        end
        else if (rq.action == ehtu_pkg::ACT_INSERT)
            r.status = insert_key(rq.key, rq.value);
        else if (rq.action == ehtu_pkg::ACT_REMOVE)
        begin
            at = find_slot(bucket_of(rq.key), rq.key);
            if (at >= 0)
            begin
                slot_used[at] = 0;
                r.status = ehtu_pkg::ST_OK;
            end
        end
        r.depth_now = 3'(gdepth);
        r.bucket_count = 7'(nbuckets);
        r.key_local_depth = 3'(bkt_depth[bucket_of(rq.key)]);
        pending_rsp.push_back(r);
    endfunction

    function void report(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        mismatches++;
    endfunction

    // compare one response with the oldest prediction
    function void check_response(ehtu_pkg::ehtu_rsp_t r);
        ehtu_pkg::ehtu_rsp_t e;
        if (pending_rsp.size() == 0)
        begin
            report("unexpected response", longint'(r.status), 0);
            return;
        end
        e = pending_rsp.pop_front();
        if (r.status !== e.status) report("status", r.status, e.status);
        if (r.found_value !== e.found_value) report("found_value", r.found_value, e.found_value);
        if (r.depth_now !== e.depth_now) report("depth_now", r.depth_now, e.depth_now);
        if (r.bucket_count !== e.bucket_count)
            report("bucket_count", r.bucket_count, e.bucket_count);
        if (r.key_local_depth !== e.key_local_depth)
            report("key_local_depth", r.key_local_depth, e.key_local_depth);
    endfunction
endclass

module tb_extendible_hash_table_unit;
    import ehtu_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [ACT_W-1:0] ACT_UNKNOWN = 2'd3;

    logic      clk = 0;
    logic      rst_n = 0;
    logic      start = 0;
    logic      busy;
    ehtu_req_t req = '0;
    logic      done;
    ehtu_rsp_t rsp;
    logic      cfg_wr_en = 0;
    logic [CAP_W-1:0] cfg_wr_data = '0;

    ehtu_scoreboard table_model = new();
    int  gap_pct = 0;
    int  cycles = 0;
    bit [31:0] key_pool [$];

    extendible_hash_table_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .rsp(rsp), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always #5 clk = ~clk;

    // response check and run limit
    always @(posedge clk)
    begin
        cycles++;
        if (done === 1'b1) table_model.check_response(rsp);
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL extendible_hash_table_unit");
            $finish;
        end
    end

    // issue one request and wait for the handshake
    task automatic send_request(logic [1:0] act, logic [31:0] k, logic [31:0] v);
        while (gap_pct > 0 && $urandom_range(99) < gap_pct) @(posedge clk);
        start <= 1;
        req <= '{action: act, key: k, value: v};
        @(posedge clk);
        while (busy !== 1'b0) @(posedge clk);
        table_model.note_request(req);
        start <= 0;
        // the block stays busy past this edge, so no request slot is lost
        @(posedge clk);
    endtask

    // wait until idle, then write the capacity register
    task automatic write_capacity(logic [3:0] c);
        while (table_model.pending_rsp.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        cfg_wr_en <= 1;
        cfg_wr_data <= c;
        @(posedge clk);
        table_model.capacity = c;
        cfg_wr_en <= 0;
    endtask

    function automatic logic [31:0] pick_key();
        if (key_pool.size() > 0 && $urandom_range(99) < 65)
            return key_pool[$urandom_range(key_pool.size() - 1)];
        return ($urandom_range(3) == 0) ? $urandom : $urandom_range(255);
    endfunction

    task automatic random_phase(int n);
        logic [31:0] k;
        int pick;
        for (int i = 0; i < n; i++)
        begin
            k = pick_key();
            pick = $urandom_range(99);
            if (pick < 50)
            begin
                send_request(ACT_INSERT, k, $urandom);
                if (key_pool.size() < 200) key_pool.push_back(k);
            end
            else if (pick < 75) send_request(ACT_FIND, k, $urandom);
            else if (pick < 97) send_request(ACT_REMOVE, k, $urandom);
            else send_request(ACT_UNKNOWN, k, $urandom);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1;

        // directed: extremes, every action, overwrite, unknown action
        send_request(ACT_FIND, 32'h0, 32'h0);
        send_request(ACT_INSERT, 32'h0, 32'hFFFF_FFFF);
        send_request(ACT_INSERT, 32'hFFFF_FFFF, 32'h0);
        send_request(ACT_FIND, 32'h0, 32'h1234);
        send_request(ACT_FIND, 32'hFFFF_FFFF, 32'h0);
        send_request(ACT_INSERT, 32'h0, 32'hA5A5_5A5A);
        send_request(ACT_FIND, 32'h0, 32'h0);
        send_request(ACT_UNKNOWN, 32'h0, 32'hFFFF_FFFF);
        send_request(ACT_REMOVE, 32'hFFFF_FFFF, 32'h0);
        send_request(ACT_REMOVE, 32'hFFFF_FFFF, 32'h0);
        send_request(ACT_FIND, 32'hFFFF_FFFF, 32'h0);
        // keys sharing low bits force splits up to full depth
        for (int i = 0; i < 8; i++) send_request(ACT_INSERT, 32'h40 * i, i);
        send_request(ACT_INSERT, 32'h8000_0000, 32'h5);
        send_request(ACT_FIND, 32'h40, 32'h0);

        // capacity one, with lowered capacity below occupancy
        write_capacity(4'd1);
        send_request(ACT_INSERT, 32'h0, 32'h77);
        send_request(ACT_INSERT, 32'h0000_0200, 32'h1);
        gap_pct = 16;
        random_phase(250);

        // out of range codes, then in-range codes 8 and 3
        write_capacity(4'd0);
        random_phase(150);
        write_capacity(4'd15);
        gap_pct = 59;
        random_phase(250);
        write_capacity(4'd8);
        random_phase(250);
        write_capacity(4'd3);
        gap_pct = 0;
        random_phase(330);

        while (table_model.pending_rsp.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (table_model.mismatches == 0)
            $display("PASS extendible_hash_table_unit");
        else
            $display("FAIL extendible_hash_table_unit");
        $finish;
    end
endmodule

/* filelist.f */
design/ehtu_pkg.sv
design/ehtu_ram.sv
design/extendible_hash_table_unit.sv
bench/tb_extendible_hash_table_unit.sv
